// ===== rtl/core/lfu_cache_policy_defines.svh =====
// lfu_cache_policy_defines.svh: assertion macros for the LFU store.
// Has no dependencies; included by files that carry assertions.
`ifndef LFU_CACHE_POLICY_DEFINES_SVH
`define LFU_CACHE_POLICY_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define LFU_ASSERT_HOLD(label, clk_s, rst_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
		else $error("lfu_cache_policy: assertion failed");

// next-cycle implication, disabled while reset is asserted
`define LFU_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
		else $error("lfu_cache_policy: assertion failed");

`endif

// ===== rtl/core/lfu_pkg.sv =====
// lfu_pkg: shared types and constants of the LFU cache policy block.
// No dependencies; used by lfu_scan and lfu_cache_policy.
package lfu_pkg;

	// operation codes of the kind field
	localparam logic KIND_GET = 1'b0;
	localparam logic KIND_PUT = 1'b1;

	// value returned by a lookup that misses
	localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

	// configuration port
	localparam int          APB_ADDR_W   = 3;
	localparam logic [0:0]  REG_CAPACITY = 1'b0;
	localparam logic [4:0]  CAP_RESET    = 5'd16;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DECIDE = 4'b0100,
		ST_RANK   = 4'b1000
	} lfu_state_t;

	// scan summary flags handed from the compare unit to the sequencer
	typedef struct packed {
		logic hit;    // key match found
		logic vic;    // a valid entry exists to evict
		logic free;   // an empty slot exists
	} scan_flags_t;

endpackage

// ===== rtl/core/lfu_ram.sv =====
// lfu_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies; instanced for entry data and recency ranks.
module lfu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/lfu_scan.sv =====
// lfu_scan: shared compare unit; looks at one entry per cycle and keeps the
// key match, the eviction victim and the first empty slot. Uses lfu_pkg.
module lfu_scan #(
	parameter int ENTRIES    = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       clr,
	input  logic                                       en,
	input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] idx,
	input  logic                                       ent_valid,
	input  logic [31:0]                                req_key,
	input  logic [31:0]                                rd_key,
	input  logic [31:0]                                rd_value,
	input  logic [COUNT_BITS-1:0]                      rd_count,
	input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_rank,
	output lfu_pkg::scan_flags_t                       flags,
	output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] hit_idx,
	output logic [31:0]                                hit_value,
	output logic [COUNT_BITS-1:0]                      hit_count,
	output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] hit_rank,
	output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] vic_idx,
	output logic [31:0]                                vic_key,
	output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] vic_rank,
	output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] free_idx
);
	import lfu_pkg::*;

	scan_flags_t           flags_q;
	logic [COUNT_BITS-1:0] vic_count_q;
	logic                  key_eq;
	logic                  vic_better;

	// compare unit: key equality and victim order (lower count, then older)
	assign key_eq     = ent_valid && (rd_key == req_key);
	assign vic_better = ent_valid && (!flags_q.vic || (rd_count < vic_count_q) ||
		((rd_count == vic_count_q) && (rd_rank > vic_rank)));

	// summary flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (clr) begin
			flags_q <= '0;
		end else if (en) begin
			if (key_eq && !flags_q.hit) flags_q.hit <= 1'b1;
			if (vic_better) flags_q.vic <= 1'b1;
			if (!ent_valid && !flags_q.free) flags_q.free <= 1'b1;
		end
	end

	// captured entry fields
	always_ff @(posedge clk) begin
		if (en) begin
			if (key_eq && !flags_q.hit) begin
				hit_idx   <= idx;
				hit_value <= rd_value;
				hit_count <= rd_count;
				hit_rank  <= rd_rank;
			end
			if (vic_better) begin
				vic_idx     <= idx;
				vic_key     <= rd_key;
				vic_count_q <= rd_count;
				vic_rank    <= rd_rank;
			end
			if (!ent_valid && !flags_q.free) begin
				free_idx <= idx;
			end
		end
	end

	assign flags = flags_q;

endmodule

// ===== rtl/core/lfu_cache_policy.sv =====
// lfu_cache_policy: LFU key-value store with LRU tie-break, top level.
// Depends on lfu_pkg, lfu_ram, lfu_scan and lfu_cache_policy_defines.svh.
//
//   channel   signals                                   handshake
//   config    psel penable pwrite paddr pwdata prdata   APB, pready tied high
//   request   kind key value                            start while !busy
//   result    hit read_value evicted evicted_key        done strobe, one cycle
//
// Each request makes one pass over the entry RAMs (one entry per cycle through
// the read port) to find match, victim and free slot, then a decision state;
// all but a lookup that misses or a store with no slot then make one pass
// over the rank RAM to age entries. done pulses in the cycle that busy
// falls. Reset clears valid bits and occupancy at once; no clearing pass.
// The result cannot be stalled; it stays on the ports until the decision
// cycle of the next request.
`include "lfu_cache_policy_defines.svh"

module lfu_cache_policy #(
	parameter int ENTRIES    = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lfu_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	// request
	input  logic                             start,
	output logic                             busy,
	input  logic                             kind,
	input  logic [31:0]                      key,
	input  logic signed [31:0]               value,
	// result
	output logic                             done,
	output logic                             hit,
	output logic signed [31:0]               read_value,
	output logic                             evicted,
	output logic [31:0]                      evicted_key
);
	import lfu_pkg::*;

	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int OCC_W  = $clog2(ENTRIES + 1);
	localparam int LIM_W  = (OCC_W > 5) ? OCC_W : 5;
	localparam int DATA_W = 64 + COUNT_BITS;

	lfu_state_t       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             chk_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [ENTRIES-1:0] valid_q;
	logic [OCC_W-1:0] occ_q;
	logic [4:0]       cap_q;
	logic             done_q;

	logic             kind_q;
	logic [31:0]      key_q;
	logic [31:0]      value_q;

	logic [IDX_W-1:0] dest_q;
	logic [IDX_W-1:0] ref_q;
	logic             age_all_q;

	logic             hit_q;
	logic [31:0]      rv_q;
	logic             ev_q;
	logic [31:0]      evk_q;

	// RAM signals
	logic [DATA_W-1:0] data_rd;
	logic [IDX_W-1:0]  rank_rd;
	logic              rank_we;
	logic [IDX_W-1:0]  rank_wdata;
	logic [IDX_W-1:0]  rd_addr;

	// scan unit signals
	scan_flags_t           sflags;
	logic [IDX_W-1:0]      hit_idx;
	logic [31:0]           hit_value;
	logic [COUNT_BITS-1:0] hit_count;
	logic [IDX_W-1:0]      hit_rank;
	logic [IDX_W-1:0]      vic_idx;
	logic [31:0]           vic_key;
	logic [IDX_W-1:0]      vic_rank;
	logic [IDX_W-1:0]      free_idx;

	// decision signals
	logic [LIM_W-1:0]      cap_ext;
	logic [LIM_W-1:0]      limit;
	logic                  need_evict;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic                  d_go_rank;
	logic                  d_we;
	logic [IDX_W-1:0]      d_dest;
	logic [IDX_W-1:0]      d_ref;
	logic                  d_age_all;
	logic                  d_set;
	logic                  d_clr;
	logic                  d_occ_inc;
	logic                  d_hit;
	logic [31:0]           d_rv;
	logic                  d_ev;
	logic [31:0]           d_evk;
	logic [31:0]           d_wval;
	logic [COUNT_BITS-1:0] d_wcnt;

	logic accept;
	logic cfg_wr;
	logic sweep_end;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign pready    = 1'b1;
	assign sweep_end = (cnt_q == CNT_W'(ENTRIES));
	assign rd_addr   = cnt_q[IDX_W-1:0];

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr && (paddr[APB_ADDR_W-1:2] == REG_CAPACITY)) begin
			cap_q <= pwdata[4:0];
		end
	end

	assign prdata = (paddr[APB_ADDR_W-1:2] == REG_CAPACITY) ? {27'b0, cap_q} : 32'b0;

	// entry RAMs: {key, value, count} and recency rank
	lfu_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_data_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_dest),
		.wdata ({key_q, d_wval, d_wcnt}),
		.raddr (rd_addr),
		.rdata (data_rd)
	);

	lfu_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_rank_ram (
		.clk   (clk),
		.we    (rank_we),
		.waddr (idx_s1),
		.wdata (rank_wdata),
		.raddr (rd_addr),
		.rdata (rank_rd)
	);

	// compare unit over the first pass
	lfu_scan #(.ENTRIES(ENTRIES), .COUNT_BITS(COUNT_BITS)) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (accept),
		.en        ((state_q == ST_SCAN) && chk_s1),
		.idx       (idx_s1),
		.ent_valid (valid_q[idx_s1]),
		.req_key   (key_q),
		.rd_key    (data_rd[DATA_W-1 -: 32]),
		.rd_value  (data_rd[COUNT_BITS +: 32]),
		.rd_count  (data_rd[COUNT_BITS-1:0]),
		.rd_rank   (rank_rd),
		.flags     (sflags),
		.hit_idx   (hit_idx),
		.hit_value (hit_value),
		.hit_count (hit_count),
		.hit_rank  (hit_rank),
		.vic_idx   (vic_idx),
		.vic_key   (vic_key),
		.vic_rank  (vic_rank),
		.free_idx  (free_idx)
	);

	// effective capacity: zero acts as one, clipped to the entry count
	assign cap_ext    = LIM_W'(cap_q);
	assign limit      = (cap_q == 5'd0) ? LIM_W'(1) :
		((cap_ext > LIM_W'(ENTRIES)) ? LIM_W'(ENTRIES) : cap_ext);
	assign need_evict = (LIM_W'(occ_q) >= limit);
	assign cnt_inc    = (&hit_count) ? hit_count : hit_count + COUNT_BITS'(1);

	// decision after the scan
	always_comb begin
		d_go_rank = 1'b0;
		d_we      = 1'b0;
		d_dest    = hit_idx;
		d_ref     = hit_rank;
		d_age_all = 1'b0;
		d_set     = 1'b0;
		d_clr     = 1'b0;
		d_occ_inc = 1'b0;
		d_hit     = sflags.hit;
		d_rv      = 32'b0;
		d_ev      = 1'b0;
		d_evk     = 32'b0;
		d_wval    = value_q;
		d_wcnt    = cnt_inc;
		if (state_q == ST_DECIDE) begin
			if (sflags.hit) begin
				// touch the matching entry
				d_go_rank = 1'b1;
				d_we      = 1'b1;
				if (kind_q == KIND_GET) begin
					d_wval = hit_value;
					d_rv   = hit_value;
				end
			end else if (kind_q == KIND_GET) begin
				d_rv = MISS_VALUE;
			end else if (need_evict && sflags.vic) begin
				// evict and refill: entries younger than the victim age by one
				d_ev      = 1'b1;
				d_evk     = vic_key;
				d_ref     = vic_rank;
				d_dest    = (sflags.free && (free_idx < vic_idx)) ? free_idx : vic_idx;
				d_clr     = 1'b1;
				d_set     = 1'b1;
				d_we      = 1'b1;
				d_wcnt    = COUNT_BITS'(1);
				d_go_rank = 1'b1;
			end else if (sflags.free) begin
				// plain insert: every valid entry ages by one
				d_dest    = free_idx;
				d_age_all = 1'b1;
				d_set     = 1'b1;
				d_occ_inc = 1'b1;
				d_we      = 1'b1;
				d_wcnt    = COUNT_BITS'(1);
				d_go_rank = 1'b1;
			end
		end
	end

	// rank sweep: new or touched entry to zero, younger ones age by one
	always_comb begin
		rank_we    = 1'b0;
		rank_wdata = rank_rd + IDX_W'(1);
		if ((state_q == ST_RANK) && chk_s1) begin
			if (idx_s1 == dest_q) begin
				rank_we    = 1'b1;
				rank_wdata = '0;
			end else if (valid_q[idx_s1] && (age_all_q || (rank_rd < ref_q))) begin
				rank_we = 1'b1;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			chk_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					cnt_q  <= '0;
					chk_s1 <= 1'b0;
					if (accept) state_q <= ST_SCAN;
				end
				ST_SCAN, ST_RANK: begin
					chk_s1 <= !sweep_end;
					cnt_q  <= sweep_end ? '0 : cnt_q + CNT_W'(1);
					if (sweep_end) begin
						if (state_q == ST_SCAN) begin
							state_q <= ST_DECIDE;
						end else begin
							state_q <= ST_IDLE;
							done_q  <= 1'b1;
						end
					end
				end
				ST_DECIDE: begin
					cnt_q  <= '0;
					chk_s1 <= 1'b0;
					if (d_go_rank) begin
						state_q <= ST_RANK;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					cnt_q   <= '0;
					chk_s1  <= 1'b0;
				end
			endcase
		end
	end

	// index of the entry whose read data arrives next cycle
	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
	end

	// valid bits and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
		end else if (state_q == ST_DECIDE) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (d_set && (d_dest == IDX_W'(i))) begin
					valid_q[i] <= 1'b1;
				end else if (d_clr && (vic_idx == IDX_W'(i))) begin
					valid_q[i] <= 1'b0;
				end
			end
			if (d_occ_inc) occ_q <= occ_q + OCC_W'(1);
		end
	end

	// request capture, sweep parameters and result beat
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= kind;
			key_q   <= key;
			value_q <= $unsigned(value);
		end
		if (state_q == ST_DECIDE) begin
			dest_q    <= d_dest;
			ref_q     <= d_ref;
			age_all_q <= d_age_all;
			hit_q     <= d_hit;
			rv_q      <= d_rv;
			ev_q      <= d_ev;
			evk_q     <= d_evk;
		end
	end

	assign done        = done_q;
	assign hit         = hit_q;
	assign read_value  = $signed(rv_q);
	assign evicted     = ev_q;
	assign evicted_key = evk_q;

	// checks
	`LFU_ASSERT_HOLD(a_done_idle, clk, arst_n, done, state_q == ST_IDLE)
	`LFU_ASSERT_NEXT(a_start_scan, clk, arst_n, start && !busy, state_q == ST_SCAN)
	`LFU_ASSERT_HOLD(a_evict_put_miss, clk, arst_n, done && evicted, (kind_q == KIND_PUT) && !hit)
	`LFU_ASSERT_HOLD(a_occ_bound, clk, arst_n, 1'b1, occ_q <= OCC_W'(ENTRIES))

endmodule
